/* hdl/dca_pkg.sv */
// Shared types and codes for the descriptor chain allocator.
// Holds the command codes and the sequencer state type; no dependencies.
package dca_pkg;

  localparam logic [1:0] CMD_INIT  = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam int unsigned MIN_SIZE = 4;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_INIT  = 6'b000010,
    ST_AWALK = 6'b000100,
    ST_FWALK = 6'b001000,
    ST_DONE  = 6'b010000,
    ST_SPARE = 6'b100000
  } dca_state_t;

endpackage

/* hdl/descriptor_chain_allocator_core.sv */
// Descriptor chain allocator: free list of descriptors linked through a table.
// Depends on dca_pkg and dca_ram (link and continue flag table).
//
//  channel  ports                                         handshake
//  -------  --------------------------------------------  ------------------
//  cfg      cfg_we, cfg_wdata                             write on cfg_we
//  in       in_cmd, in_chain_length, in_chain_head        in_valid / in_stall
//  out      out_status, out_alloc_head, out_free_count    out_valid / out_stall
//
// One beat in gives one beat out. A sequencer walks one table entry per cycle
// through the single read port of the table RAM: init writes size entries,
// allocate walks n entries, free walks the chain, and reject and no-op walk none.
// Reset clears head, free count and queue_size (to 256); the table is not cleared.
// in_stall is high while a command runs; a stalled result holds the sequencer.
module descriptor_chain_allocator_core
  import dca_pkg::*;
#(
  parameter int MAX_QUEUE = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [8:0] in_chain_length,
  input  logic [7:0] in_chain_head,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_status,
  output logic [7:0] out_alloc_head,
  output logic [8:0] out_free_count
);

  localparam int IDX_W = $clog2(MAX_QUEUE);
  localparam int CNT_W = $clog2(MAX_QUEUE + 1);
  localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_QUEUE);

  function automatic logic [IDX_W-1:0] wrap_head(input logic [7:0] h);
    logic [7:0] v;
    v = h;
    for (int k = 7; k >= 0; k--) begin
      if ({24'd0, v} >= (32'(MAX_QUEUE) << k)) begin
        v = v - 8'(32'(MAX_QUEUE) << k);
      end
    end
    return IDX_W'(v);
  endfunction

  function automatic logic [CNT_W-1:0] usable_size(input logic [8:0] qs);
    logic [CMP_W-1:0] s;
    logic [CMP_W-1:0] p;
    s = CMP_W'(qs);
    if (s > CMP_W'(MAX_QUEUE)) begin
      s = CMP_W'(MAX_QUEUE);
    end
    p = '0;
    for (int i = 0; i < CMP_W; i++) begin
      if (s[i]) begin
        p = CMP_W'(1) << i;
      end
    end
    return CNT_W'(p);
  endfunction

  dca_state_t       state_r, state_nxt;
  logic [8:0]       qsize_r, qsize_nxt;
  logic [IDX_W-1:0] list_head_r, list_head_nxt;
  logic [CNT_W-1:0] free_total_r, free_total_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] size_r, size_nxt;
  logic [IDX_W-1:0] fhead_r, fhead_nxt;
  logic             res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_head_r, res_head_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_status_r, out_status_nxt;
  logic [7:0]       out_head_r, out_head_nxt;
  logic [8:0]       out_count_r, out_count_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W:0]   ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  logic [IDX_W:0]   ram_rdata;
  logic [IDX_W-1:0] rd_link;
  logic             rd_flag;
  logic [CNT_W-1:0] size_in;
  logic [CNT_W:0]   cnt_inc;
  logic             in_beat;

  assign rd_link = ram_rdata[IDX_W-1:0];
  assign rd_flag = ram_rdata[IDX_W];
  assign size_in = usable_size(qsize_r);
  assign cnt_inc = {1'b0, cnt_r} + 1'b1;
  assign in_stall = (state_r != ST_IDLE);
  assign in_beat = in_valid && (state_r == ST_IDLE);

  dca_ram #(
    .WIDTH (IDX_W + 1),
    .DEPTH (MAX_QUEUE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    qsize_nxt      = cfg_we ? cfg_wdata : qsize_r;
    list_head_nxt  = list_head_r;
    free_total_nxt = free_total_r;
    cur_nxt        = cur_r;
    cnt_nxt        = cnt_r;
    len_nxt        = len_r;
    size_nxt       = size_r;
    fhead_nxt      = fhead_r;
    res_status_nxt = res_status_r;
    res_head_nxt   = res_head_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_head_nxt   = out_head_r;
    out_count_nxt  = out_count_r;
    ram_we         = 1'b0;
    ram_waddr      = cur_r;
    ram_wdata      = '0;
    ram_raddr      = rd_link;

    unique case (state_r)
      ST_IDLE: begin
        ram_raddr = (in_cmd == CMD_FREE) ? wrap_head(in_chain_head) : list_head_r;
        if (in_beat) begin
          res_status_nxt = 1'b0;
          res_head_nxt   = '0;
          case (in_cmd)
            CMD_INIT: begin
              if (size_in < CNT_W'(MIN_SIZE)) begin
                res_status_nxt = 1'b1;
                state_nxt      = ST_DONE;
              end else begin
                size_nxt  = size_in;
                cnt_nxt   = '0;
                state_nxt = ST_INIT;
              end
            end
            CMD_ALLOC: begin
              if (in_chain_length == 9'd0 ||
                  CMP_W'(in_chain_length) > CMP_W'(free_total_r)) begin
                res_status_nxt = 1'b1;
                state_nxt      = ST_DONE;
              end else begin
                len_nxt      = CNT_W'(in_chain_length);
                cnt_nxt      = CNT_W'(1);
                cur_nxt      = list_head_r;
                res_head_nxt = list_head_r;
                state_nxt    = ST_AWALK;
              end
            end
            CMD_FREE: begin
              cur_nxt   = wrap_head(in_chain_head);
              fhead_nxt = wrap_head(in_chain_head);
              cnt_nxt   = CNT_W'(1);
              state_nxt = ST_FWALK;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(cnt_r);
        ram_wdata = (cnt_inc < {1'b0, size_r}) ? {1'b0, IDX_W'(cnt_inc)} : '0;
        cnt_nxt   = CNT_W'(cnt_inc);
        if (cnt_r == size_r - 1'b1) begin
          list_head_nxt  = '0;
          free_total_nxt = size_r;
          state_nxt      = ST_DONE;
        end
      end
      ST_AWALK: begin
        ram_we = 1'b1;
        if (cnt_r < len_r) begin
          ram_wdata = {1'b1, rd_link};
          cur_nxt   = rd_link;
          cnt_nxt   = CNT_W'(cnt_inc);
        end else begin
          ram_wdata      = '0;
          list_head_nxt  = rd_link;
          free_total_nxt = free_total_r - len_r;
          state_nxt      = ST_DONE;
        end
      end
      ST_FWALK: begin
        if (free_total_r != MAX_CNT) begin
          free_total_nxt = free_total_r + 1'b1;
        end
        if (!rd_flag || cnt_r >= MAX_CNT) begin
          ram_we        = 1'b1;
          ram_wdata     = {rd_flag, list_head_r};
          list_head_nxt = fhead_r;
          state_nxt     = ST_DONE;
        end else begin
          cur_nxt = rd_link;
          cnt_nxt = CNT_W'(cnt_inc);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_head_nxt   = 8'(res_head_r);
          out_count_nxt  = 9'(free_total_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      qsize_r      <= 9'd256;
      list_head_r  <= '0;
      free_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      qsize_r      <= qsize_nxt;
      list_head_r  <= list_head_nxt;
      free_total_r <= free_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    cnt_r        <= cnt_nxt;
    len_r        <= len_nxt;
    size_r       <= size_nxt;
    fhead_r      <= fhead_nxt;
    res_status_r <= res_status_nxt;
    res_head_r   <= res_head_nxt;
    out_status_r <= out_status_nxt;
    out_head_r   <= out_head_nxt;
    out_count_r  <= out_count_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_head = out_head_r;
  assign out_free_count = out_count_r;

endmodule

/* hdl/dca_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; read returns the old contents on a same-address write.
module dca_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
